### hw/rtl/arcp_pkg.sv
// Shared constants, types and helper functions for the arc pose pipeline.
package arcp_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  localparam int REG_W   = 24;
  localparam int CX_W    = 34;
  localparam int CR_W    = 36;
  localparam int TWOPI_W = 35;

  localparam logic [1:0] CFG_CURVATURE  = 2'd0;
  localparam logic [1:0] CFG_ARC_LENGTH = 2'd1;
  localparam logic [1:0] CFG_TURN       = 2'd2;

  localparam logic signed [CR_W-1:0] TWO_PI_Q32  = 36'sd26986075409;
  localparam logic signed [CR_W-1:0] PI_Q32      = 36'sd13493037705;
  localparam logic signed [CR_W-1:0] HALF_PI_Q32 = 36'sd6746518852;
  localparam logic signed [CX_W-1:0] CORDIC_K    = 34'sd652032874;

  typedef struct packed {
    logic        [31:0] heading;
    logic signed [23:0] px0;
    logic        [23:0] plen;
    logic        [30:0] alen;
    logic               curved;
    logic               rneg;
    logic               negc;
    logic               negx;
    logic               negy;
  } side_t;

  // Arctangent of 2^-idx, stored in Q30 and scaled by four to a Q32 angle.
  function automatic logic signed [CR_W-1:0] atan4(input int idx);
    logic [31:0] a;
    begin
      case (idx)
        0:  a = 32'h3243F6A8;
        1:  a = 32'h1DAC6705;
        2:  a = 32'h0FADBAFC;
        3:  a = 32'h07F56EA6;
        4:  a = 32'h03FEAB76;
        5:  a = 32'h01FFD55B;
        6:  a = 32'h00FFFAAA;
        7:  a = 32'h007FFF55;
        8:  a = 32'h003FFFEA;
        9:  a = 32'h001FFFFD;
        10: a = 32'h000FFFFF;
        11: a = 32'h0007FFFF;
        12: a = 32'h0003FFFF;
        13: a = 32'h0001FFFF;
        14: a = 32'h0000FFFF;
        15: a = 32'h00007FFF;
        16: a = 32'h00003FFF;
        17: a = 32'h00001FFF;
        18: a = 32'h00000FFF;
        19: a = 32'h000007FF;
        20: a = 32'h000003FF;
        21: a = 32'h000001FF;
        22: a = 32'h000000FF;
        23: a = 32'h0000007F;
        default: a = 32'h0;
      endcase
      return signed'({2'b00, a, 2'b00});
    end
  endfunction

  // Shift right by n with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned n);
    logic [63:0] m;
    begin
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (n - 1))) >> n;
      return v[63] ? -signed'(m) : signed'(m);
    end
  endfunction

endpackage

### hw/rtl/arcp_sub_cell.sv
// One restoring step: subtract a shifted divisor when it fits and record the quotient bit.
module arcp_sub_cell #(
  parameter int REM_W = 36,
  parameter int DIV_W = 24,
  parameter int SHIFT = 0,
  parameter int Q_W   = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [REM_W-1:0] rem_i,
  input  logic [Q_W-1:0]   q_i,
  input  logic [DIV_W-1:0] div_i,
  output logic [REM_W-1:0] rem_o,
  output logic [Q_W-1:0]   q_o
);

  localparam int CW = (REM_W > DIV_W + SHIFT) ? REM_W : DIV_W + SHIFT;

  logic [CW-1:0]    rem_w;
  logic [CW-1:0]    sub_w;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;
  logic [Q_W-1:0]   q_nxt;
  logic [REM_W-1:0] rem_r;
  logic [Q_W-1:0]   q_r;

  always_comb begin
    rem_w   = CW'(rem_i);
    sub_w   = CW'(div_i) << SHIFT;
    ge      = (rem_w >= sub_w);
    rem_nxt = ge ? REM_W'(rem_w - sub_w) : rem_i;
    q_nxt   = {q_i[Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

### hw/rtl/arcp_cordic_cell.sv
// One CORDIC rotation step in Q30 with a Q32 residual angle.
module arcp_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [arcp_pkg::CX_W-1:0] x_i,
  input  logic signed [arcp_pkg::CX_W-1:0] y_i,
  input  logic signed [arcp_pkg::CR_W-1:0] r_i,
  output logic signed [arcp_pkg::CX_W-1:0] x_o,
  output logic signed [arcp_pkg::CX_W-1:0] y_o,
  output logic signed [arcp_pkg::CR_W-1:0] r_o
);

  localparam logic signed [arcp_pkg::CR_W-1:0] ANG = arcp_pkg::atan4(IDX);

  logic signed [arcp_pkg::CX_W-1:0] xs, ys;
  logic signed [arcp_pkg::CX_W-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [arcp_pkg::CR_W-1:0] r_nxt, r_r;

  always_comb begin
    xs = x_i >>> IDX;
    ys = y_i >>> IDX;
    if (!r_i[arcp_pkg::CR_W-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      r_nxt = r_i - ANG;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      r_nxt = r_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      r_r <= r_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign r_o = r_r;

endmodule

### hw/rtl/arc_pose_at_fraction.sv
// Top level: pipelined pose on a constant-curvature arc at a clamped fraction.
//
//  channel | direction | handshake          | word
//  in      | sink      | in_valid/in_stall  | in_fraction
//  out     | source    | out_valid/out_stall| heading, pos_x/y, path and angular length
//  cfg     | sink      | cfg_wr_en          | cfg_index, cfg_data
//
// One word enters per cycle while the output is not stalled. The pipeline holds
// NRED = max(44 - 2*FRAC_BITS, 1) angle reduction cells and NUM_W =
// max(2*FRAC_BITS + 3, 24) + 1 divider cells.
// Reset clears the configuration registers and the pipeline valid bits.
// A stalled output word freezes the whole pipeline, which stalls the input.
module arc_pose_at_fraction #(
  parameter int FRAC_BITS     = arcp_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = arcp_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_fraction,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_heading,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_path_length,
  output logic        [30:0] out_angular_length,
  input  logic               cfg_wr_en,
  input  logic        [1:0]  cfg_index,
  input  logic        [23:0] cfg_data
);

  localparam int F     = FRAC_BITS;
  localparam int NC    = CORDIC_STAGES;
  localparam int CMP_W = (F + 2 > 18) ? F + 2 : 18;
  localparam int RW    = (79 - 2 * F > 36) ? 79 - 2 * F : 36;
  localparam int NRED  = (44 - 2 * F > 1) ? 44 - 2 * F : 1;
  localparam int NUM_W = ((2 * F + 3 > 24) ? 2 * F + 3 : 24) + 1;
  localparam int CX_W  = arcp_pkg::CX_W;
  localparam int CR_W  = arcp_pkg::CR_W;
  localparam logic signed [CMP_W-1:0] ONE_C = CMP_W'(1) <<< F;

  // Configuration registers.
  logic signed [23:0] curv_r, len_r;
  logic               tip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curv_r <= '0;
      len_r  <= '0;
      tip_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        arcp_pkg::CFG_CURVATURE:  curv_r <= cfg_data;
        arcp_pkg::CFG_ARC_LENGTH: len_r  <= cfg_data;
        arcp_pkg::CFG_TURN:       tip_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic        adv;
  logic        k_neg;
  logic [23:0] k_mag, a_mag;
  logic        out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;
  assign k_neg    = curv_r[23];
  assign k_mag    = k_neg ? 24'(-curv_r) : 24'(curv_r);
  assign a_mag    = len_r[23] ? 24'(-len_r) : 24'(len_r);

  // Stage A: clamp and the two products.
  logic signed [CMP_W-1:0]    f_ext, fc;
  logic signed [CMP_W+23:0]   pfa_r;
  logic signed [47:0]         pak_r;
  logic                       va_r;

  always_comb begin
    f_ext = CMP_W'(in_fraction);
    if (f_ext < 0)          fc = '0;
    else if (f_ext > ONE_C) fc = ONE_C;
    else                    fc = f_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (adv) va_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pfa_r <= fc * len_r;
      pak_r <= len_r * curv_r;
    end
  end

  // Stage B: distance along the arc and the per-mode constant outputs.
  logic signed [63:0] s64, am64;
  logic        [63:0] amag;
  logic signed [23:0] s_w;
  logic        [23:0] s_mag;
  arcp_pkg::side_t    side_b;
  arcp_pkg::side_t    side_b_r;
  logic signed [23:0] s_r;
  logic               vb_r;

  always_comb begin
    s64   = arcp_pkg::rnd(64'(pfa_r), F);
    am64  = arcp_pkg::rnd(64'(pak_r), F);
    amag  = am64[63] ? 64'(-am64) : 64'(am64);
    s_w   = s64[23:0];
    s_mag = s_w[23] ? 24'(-s_w) : 24'(s_w);
    side_b = '0;
    if (tip_r) begin
      side_b.heading = k_neg ? -32'(s_mag) : 32'(s_mag);
      side_b.alen    = 31'(a_mag);
    end else begin
      side_b.plen = len_r;
      if (curv_r == '0) begin
        side_b.px0 = s_w;
      end else begin
        side_b.curved = 1'b1;
        side_b.alen   = (amag > 64'h7FFFFFFF) ? 31'h7FFFFFFF : amag[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (adv) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r      <= s_w;
      side_b_r <= side_b;
    end
  end

  // Stage C: angle product.
  logic signed [47:0] prod_r;
  arcp_pkg::side_t    side_c_r;
  logic               vc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (adv) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= s_r * curv_r;
      side_c_r <= side_b_r;
    end
  end

  // Stage D: heading and the angle magnitude in Q32 for reduction.
  logic signed [63:0] t64;
  logic        [63:0] tmag;
  arcp_pkg::side_t    side_d;

  always_comb begin
    t64    = arcp_pkg::rnd(64'(prod_r), F);
    tmag   = t64[63] ? 64'(-t64) : 64'(t64);
    side_d = side_c_r;
    side_d.rneg = t64[63];
    if (side_c_r.curved) begin
      if (t64 > 64'sd2147483647)       side_d.heading = 32'h7FFFFFFF;
      else if (t64 < -64'sd2147483648) side_d.heading = 32'h80000000;
      else                             side_d.heading = t64[31:0];
    end
  end

  logic [RW-1:0]      rem_m [NRED+1];
  logic [1:0]         qm    [NRED+1];
  arcp_pkg::side_t    sm_r  [NRED+1];
  logic [NRED:0]      vm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r[0] <= 1'b0;
    else if (adv) vm_r[0] <= vc_r;
  end

  logic [RW-1:0] rem0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      rem0_r  <= RW'(tmag << (32 - F));
      sm_r[0] <= side_d;
    end
  end
  assign rem_m[0] = rem0_r;
  assign qm[0]    = '0;

  // Angle reduction modulo two pi, one shifted subtract per cell.
  for (genvar g = 0; g < NRED; g++) begin : g_mod
    arcp_sub_cell #(
      .REM_W (RW),
      .DIV_W (arcp_pkg::TWOPI_W),
      .SHIFT (NRED - 1 - g),
      .Q_W   (2)
    ) u_cell (
      .clk   (clk),
      .en    (adv),
      .rem_i (rem_m[g]),
      .q_i   (qm[g]),
      .div_i (arcp_pkg::TWOPI_W'(arcp_pkg::TWO_PI_Q32)),
      .rem_o (rem_m[g+1]),
      .q_o   (qm[g+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) vm_r[g+1] <= 1'b0;
      else if (adv) vm_r[g+1] <= vm_r[g];
    end

    always_ff @(posedge clk) begin
      if (adv) sm_r[g+1] <= sm_r[g];
    end
  end

  // Stage E: restore the sign and center into [-pi, pi).
  logic signed [CR_W-1:0] mm, rfull, rc;
  logic signed [CR_W-1:0] rr_r;
  arcp_pkg::side_t        side_e_r;
  logic                   ve_r;

  always_comb begin
    mm    = signed'(CR_W'(rem_m[NRED]));
    rfull = (sm_r[NRED].rneg && mm != '0) ? arcp_pkg::TWO_PI_Q32 - mm : mm;
    rc    = (rfull >= arcp_pkg::PI_Q32) ? rfull - arcp_pkg::TWO_PI_Q32 : rfull;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (adv) ve_r <= vm_r[NRED];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rr_r     <= rc;
      side_e_r <= sm_r[NRED];
    end
  end

  // Fold into [-pi/2, pi/2]; the cosine then flips sign.
  logic signed [CX_W-1:0] x_c [NC+1];
  logic signed [CX_W-1:0] y_c [NC+1];
  logic signed [CR_W-1:0] r_c [NC+1];
  arcp_pkg::side_t        sc_r [NC+1];
  arcp_pkg::side_t        side_f;
  logic [NC:0]            vcd_r;

  always_comb begin
    side_f = side_e_r;
    if (rr_r > arcp_pkg::HALF_PI_Q32) begin
      r_c[0]      = arcp_pkg::PI_Q32 - rr_r;
      side_f.negc = 1'b1;
    end else if (rr_r < -arcp_pkg::HALF_PI_Q32) begin
      r_c[0]      = -arcp_pkg::PI_Q32 - rr_r;
      side_f.negc = 1'b1;
    end else begin
      r_c[0]      = rr_r;
      side_f.negc = 1'b0;
    end
    sc_r[0] = side_f;
  end

  assign x_c[0]   = arcp_pkg::CORDIC_K;
  assign y_c[0]   = '0;
  assign vcd_r[0] = ve_r;

  for (genvar g = 0; g < NC; g++) begin : g_cordic
    arcp_cordic_cell #(
      .IDX (g)
    ) u_cell (
      .clk (clk),
      .en  (adv),
      .x_i (x_c[g]),
      .y_i (y_c[g]),
      .r_i (r_c[g]),
      .x_o (x_c[g+1]),
      .y_o (y_c[g+1]),
      .r_o (r_c[g+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) vcd_r[g+1] <= 1'b0;
      else if (adv) vcd_r[g+1] <= vcd_r[g];
    end

    always_ff @(posedge clk) begin
      if (adv) sc_r[g+1] <= sc_r[g];
    end
  end

  // Stage G: sine and cosine, numerators with the rounding half divisor added.
  logic signed [63:0] sn64, cs64, nx64, ny64;
  logic        [63:0] ux, uy;
  arcp_pkg::side_t    side_g;

  always_comb begin
    sn64 = arcp_pkg::rnd(64'(y_c[NC]), 30 - F);
    cs64 = arcp_pkg::rnd(64'(x_c[NC]), 30 - F);
    if (sc_r[NC].negc) cs64 = -cs64;
    nx64 = sn64 <<< F;
    ny64 = ((64'sd1 <<< F) - cs64) <<< F;
    ux   = (nx64[63] ? 64'(-nx64) : 64'(nx64)) + 64'(k_mag >> 1);
    uy   = (ny64[63] ? 64'(-ny64) : 64'(ny64)) + 64'(k_mag >> 1);
    side_g      = sc_r[NC];
    side_g.negx = nx64[63] ^ k_neg;
    side_g.negy = ny64[63] ^ k_neg;
  end

  logic [NUM_W-1:0] rx [NUM_W+1];
  logic [NUM_W-1:0] ry [NUM_W+1];
  logic [NUM_W-1:0] qx [NUM_W+1];
  logic [NUM_W-1:0] qy [NUM_W+1];
  arcp_pkg::side_t  sd_r [NUM_W+1];
  logic [NUM_W:0]   vd_r;
  logic [NUM_W-1:0] rx0_r, ry0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r[0] <= 1'b0;
    else if (adv) vd_r[0] <= vcd_r[NC];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx0_r   <= NUM_W'(ux);
      ry0_r   <= NUM_W'(uy);
      sd_r[0] <= side_g;
    end
  end

  assign rx[0] = rx0_r;
  assign ry[0] = ry0_r;
  assign qx[0] = '0;
  assign qy[0] = '0;

  // Restoring dividers by |curvature|, one quotient bit per cell.
  for (genvar g = 0; g < NUM_W; g++) begin : g_div
    arcp_sub_cell #(
      .REM_W (NUM_W),
      .DIV_W (24),
      .SHIFT (NUM_W - 1 - g),
      .Q_W   (NUM_W)
    ) u_cell_x (
      .clk   (clk),
      .en    (adv),
      .rem_i (rx[g]),
      .q_i   (qx[g]),
      .div_i (k_mag),
      .rem_o (rx[g+1]),
      .q_o   (qx[g+1])
    );

    arcp_sub_cell #(
      .REM_W (NUM_W),
      .DIV_W (24),
      .SHIFT (NUM_W - 1 - g),
      .Q_W   (NUM_W)
    ) u_cell_y (
      .clk   (clk),
      .en    (adv),
      .rem_i (ry[g]),
      .q_i   (qy[g]),
      .div_i (k_mag),
      .rem_o (ry[g+1]),
      .q_o   (qy[g+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) vd_r[g+1] <= 1'b0;
      else if (adv) vd_r[g+1] <= vd_r[g];
    end

    always_ff @(posedge clk) begin
      if (adv) sd_r[g+1] <= sd_r[g];
    end
  end

  // Output stage: sign, saturation and mode selection.
  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(8388607);
  localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(8388608);

  logic signed [23:0] px_sat, py_sat, px_nxt, py_nxt;
  arcp_pkg::side_t    so;

  always_comb begin
    so = sd_r[NUM_W];
    if (so.negx) px_sat = (qx[NUM_W] > NEG_MAX) ? 24'sh800000 : -24'(qx[NUM_W]);
    else         px_sat = (qx[NUM_W] > POS_MAX) ? 24'sh7FFFFF : 24'(qx[NUM_W]);
    if (so.negy) py_sat = (qy[NUM_W] > NEG_MAX) ? 24'sh800000 : -24'(qy[NUM_W]);
    else         py_sat = (qy[NUM_W] > POS_MAX) ? 24'sh7FFFFF : 24'(qy[NUM_W]);
    px_nxt = so.curved ? px_sat : so.px0;
    py_nxt = so.curved ? py_sat : 24'sd0;
  end

  logic signed [31:0] heading_r;
  logic signed [23:0] pos_x_r, pos_y_r, plen_r;
  logic        [30:0] alen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= vd_r[NUM_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_r <= so.heading;
      pos_x_r   <= px_nxt;
      pos_y_r   <= py_nxt;
      plen_r    <= so.plen;
      alen_r    <= so.alen;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_heading        = heading_r;
  assign out_pos_x          = pos_x_r;
  assign out_pos_y          = pos_y_r;
  assign out_path_length    = plen_r;
  assign out_angular_length = alen_r;

endmodule
